// ===== hw/rtl/hk_pkg.sv =====
// ----------------------------------------------------------------------------
// hk_pkg
// Shared types and constants for the UTF-8 hiragana to katakana converter.
// ----------------------------------------------------------------------------
package hk_pkg;

  // byte classes taken from the top two bits of a UTF-8 byte
  typedef enum logic [1:0] {
    CLS_SINGLE,
    CLS_CONT,
    CLS_LEAD
  } hk_class_t;

  // character coding constants
  localparam logic [7:0]  KANA_LEAD    = 8'hE3;
  localparam logic [7:0]  CONT_MARK    = 8'h80;
  localparam logic [11:0] HIRA_FIRST   = 12'h041;
  localparam logic [11:0] HIRA_LAST    = 12'h096;
  localparam logic [11:0] KANA_SHIFT   = 12'h060;
  localparam logic [1:0]  HELD_MAX     = 2'd3;

  // results per input byte and per queue entry
  localparam int MAX_RESULTS = 4;
  localparam int SLOT_W      = $clog2(MAX_RESULTS);
  localparam int NUM_W       = SLOT_W + 1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [QUEUE_PTR_W:0] QUEUE_FULL = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

  // one queue entry: all output bytes caused by one input byte
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [NUM_W-1:0]            num;
    logic                        text_last;
  } hk_entry_t;

  // class of a byte from its top two bits
  function automatic hk_class_t classify(input logic [7:0] b);
    hk_class_t c;
    case (b[7:6])
      2'b10:   c = CLS_CONT;
      2'b11:   c = CLS_LEAD;
      default: c = CLS_SINGLE;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/hk_front.sv =====
// ----------------------------------------------------------------------------
// hk_front
// Accepts input bytes, tracks the character being built and forms one queue
// entry holding every output byte that the input byte causes.
// ----------------------------------------------------------------------------
module hk_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              string_end,
  input  logic              queue_full,
  output logic              push_valid,
  output hk_pkg::hk_entry_t push_entry
);
  import hk_pkg::*;

  logic [7:0]  held_bytes [3];
  logic [7:0]  held_bytes_next [3];
  logic [1:0]  held_count;
  logic [1:0]  held_count_next;
  logic        pass_long;
  logic        pass_long_next;

  hk_class_t   cls;
  logic [7:0]  src [3];
  logic [7:0]  flushed [3];
  logic [1:0]  src_count;
  logic        conv_allow;
  logic        append_byte;
  logic        conv;
  logic [11:0] code;
  logic [11:0] kana_code;
  logic        accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !queue_full;
  assign cls      = classify(in_byte);

  // classify the byte and decide what to flush and what to keep
  always_comb begin
    held_bytes_next = held_bytes;
    held_count_next = held_count;
    pass_long_next  = pass_long;
    src             = held_bytes;
    src_count       = held_count;
    conv_allow      = 1'b1;
    append_byte     = 1'b0;
    case (cls)
      CLS_SINGLE: begin
        append_byte     = 1'b1;
        held_count_next = 2'd0;
        pass_long_next  = 1'b0;
      end
      CLS_CONT: begin
        if (pass_long) begin
          src_count   = 2'd0;
          append_byte = 1'b1;
        end else if (held_count != HELD_MAX) begin
          for (int i = 0; i < 3; i++) begin
            if (2'(i) == held_count) begin
              src[i]             = in_byte;
              held_bytes_next[i] = in_byte;
            end
          end
          held_count_next = held_count + 2'd1;
          src_count       = string_end ? held_count + 2'd1 : 2'd0;
        end else begin
          conv_allow      = 1'b0;
          append_byte     = 1'b1;
          held_count_next = 2'd0;
          pass_long_next  = 1'b1;
        end
      end
      CLS_LEAD: begin
        held_bytes_next[0] = in_byte;
        held_count_next    = 2'd1;
        pass_long_next     = 1'b0;
        append_byte        = string_end;
      end
      default: begin
        append_byte = 1'b1;
      end
    endcase
    if (string_end) begin
      held_count_next = 2'd0;
      pass_long_next  = 1'b0;
    end
  end

  // hiragana detection and shift to katakana
  assign code      = {src[1][5:0], src[2][5:0]};
  assign kana_code = code + KANA_SHIFT;
  assign conv      = conv_allow && (src_count == HELD_MAX) && (src[0] == KANA_LEAD) &&
                     (code >= HIRA_FIRST) && (code <= HIRA_LAST);

  always_comb begin
    flushed = src;
    if (conv) begin
      flushed[0] = KANA_LEAD;
      flushed[1] = CONT_MARK | {2'b00, kana_code[11:6]};
      flushed[2] = CONT_MARK | {2'b00, kana_code[5:0]};
    end
  end

  // pack flushed bytes then the input byte into the entry
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if ((i < 3) && (NUM_W'(i) < NUM_W'(src_count))) begin
        push_entry.bytes[i] = flushed[i % 3];
      end else begin
        push_entry.bytes[i] = in_byte;
      end
    end
    push_entry.num       = NUM_W'(src_count) + NUM_W'(append_byte);
    push_entry.text_last = string_end;
  end

  assign push_valid = accept && (push_entry.num != '0);

  // character state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      pass_long  <= 1'b0;
    end else if (accept) begin
      held_count <= held_count_next;
      pass_long  <= pass_long_next;
    end
  end

  // held bytes, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= held_bytes_next;
    end
  end

endmodule

// ===== hw/rtl/hk_queue.sv =====
// ----------------------------------------------------------------------------
// hk_queue
// Small register queue of result groups between the front and the back.
// ----------------------------------------------------------------------------
module hk_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  hk_pkg::hk_entry_t push_entry,
  input  logic              pop,
  output hk_pkg::hk_entry_t head,
  output logic              empty,
  output logic              full
);
  import hk_pkg::*;

  hk_entry_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_PTR_W:0]    count;
  logic                    do_push;
  logic                    do_pop;

  assign empty   = (count == '0);
  assign full    = (count == QUEUE_FULL);
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QUEUE_PTR_W + 1)'(1);
      end else if (!do_push && do_pop) begin
        count <= count - (QUEUE_PTR_W + 1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/hk_back.sv =====
// ----------------------------------------------------------------------------
// hk_back
// Serializes the head queue entry onto the output channel, one byte per
// transaction, and releases the entry after its last byte.
// ----------------------------------------------------------------------------
module hk_back (
  input  logic              clk,
  input  logic              rst,
  input  hk_pkg::hk_entry_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              run_last,
  output logic              text_last
);
  import hk_pkg::*;

  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic              accept;
  logic              last_slot;

  assign out_valid = !empty;
  assign accept    = out_valid && out_ready;
  assign last_slot = (NUM_W'(slot) + NUM_W'(1)) == head.num;
  assign pop       = accept && last_slot;

  // output fields from the current slot
  assign out_byte  = head.bytes[slot];
  assign run_last  = last_slot;
  assign text_last = last_slot && head.text_last;

  // slot walk
  always_comb begin
    slot_next = slot;
    if (pop) begin
      slot_next = '0;
    end else if (accept) begin
      slot_next = slot + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

// ===== hw/rtl/utf8_hiragana_to_katakana.sv =====
// ----------------------------------------------------------------------------
// utf8_hiragana_to_katakana
// Converts hiragana characters in a UTF-8 byte stream to katakana and passes
// every other character through unchanged.
//
//   channel  direction  payload                          handshake
//   input    sink       in_byte, string_end              in_valid / in_ready
//   output   source     out_byte, run_last, text_last    out_valid / out_ready
//
// An input byte is taken every cycle while the four-entry result queue is not full;
// in_ready follows the fill level only, so a pop frees room in the cycle after it.
// A byte yields one queue entry of one to four output bytes, or none while a
// character is still being built; if the queue was empty, its first byte is offered
// in the next cycle. Output goes one byte per cycle while out_ready is high; an entry
// holds the queue head until its last byte is sent. Output stalls back up into the
// queue, then in_ready drops. Reset empties the queue and clears the character state.
// ----------------------------------------------------------------------------
module utf8_hiragana_to_katakana (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       string_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       text_last
);
  import hk_pkg::*;

  logic      push_valid;
  hk_entry_t push_entry;
  hk_entry_t head;
  logic      empty;
  logic      full;
  logic      pop;

  // classify and build result groups
  hk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .string_end (string_end),
    .queue_full (full),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  // result group queue
  hk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  // byte serializer
  hk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_last (text_last)
  );

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // end of string always leaves at least one byte in the queue
  a_end_pushes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && string_end) |-> push_valid)
    else $error("string end produced no result group");

  // a queued group is never empty
  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (head.num != '0))
    else $error("empty result group at queue head");

  // the string end mark only sits on the last byte of a group
  a_text_on_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && text_last) |-> run_last)
    else $error("text_last without run_last");

endmodule
